// ===== rtl/signed_int_to_decimal_ascii_unit_assert.svh =====
// Assertion macros shared by the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define S2D_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define S2D_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/s2d_pkg.sv =====
// Shared types and constants of the decimal text converter.
package s2d_pkg;

    localparam int DefaultValueBits = 32;
    localparam int DigitBits        = 4;
    localparam int CharBits         = 6;

    localparam logic [CharBits-1:0]  CharZero  = 6'd48;
    localparam logic [CharBits-1:0]  CharMinus = 6'd45;
    localparam logic [DigitBits-1:0] DigitFive = 4'd5;
    localparam logic [DigitBits-1:0] DigitAdj  = 4'd3;
    localparam logic [DigitBits-1:0] DigitNine = 4'd9;

    typedef struct packed {
        logic busy;
        logic done;
    } t_dab_status;

endpackage

// ===== rtl/s2d_dabble.sv =====
// Bit-serial binary to BCD converter using the shift-and-add-3 method.
module s2d_dabble
    import s2d_pkg::*;
#(
    parameter int VALUE_BITS = DefaultValueBits,
    parameter int NUM_DIGITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic [VALUE_BITS-1:0]           i_mag,
    output logic [NUM_DIGITS*DigitBits-1:0] o_bcd,
    output t_dab_status                     o_status
);

    localparam int CntBits = $clog2(VALUE_BITS + 1);
    localparam int BcdBits = NUM_DIGITS * DigitBits;

    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [BcdBits-1:0]    r_bcd, n_bcd;
    logic [CntBits-1:0]    r_cnt, n_cnt;
    logic                  r_done, n_done;
    logic [BcdBits-1:0]    adj;

    // Each digit of five or more gets three added before the shift.
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*DigitBits +: DigitBits] >= DigitFive) begin
                adj[d*DigitBits +: DigitBits] = r_bcd[d*DigitBits +: DigitBits] + DigitAdj;
            end else begin
                adj[d*DigitBits +: DigitBits] = r_bcd[d*DigitBits +: DigitBits];
            end
        end
    end

    always_comb begin
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_load) begin
            n_mag = i_mag;
            n_bcd = '0;
            n_cnt = CntBits'(VALUE_BITS);
        end else if (r_cnt != '0) begin
            n_bcd  = {adj[BcdBits-2:0], r_mag[VALUE_BITS-1]};
            n_mag  = {r_mag[VALUE_BITS-2:0], 1'b0};
            n_cnt  = r_cnt - CntBits'(1);
            n_done = (r_cnt == CntBits'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_mag <= n_mag;
        r_bcd <= n_bcd;
    end

    assign o_bcd         = r_bcd;
    assign o_status.busy = (r_cnt != '0);
    assign o_status.done = r_done;

endmodule

// ===== rtl/s2d_emit.sv =====
// Character emitter: shifts BCD digits out most significant first as ASCII.
module s2d_emit
    import s2d_pkg::*;
#(
    parameter int NUM_DIGITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic                            i_neg,
    input  logic [NUM_DIGITS*DigitBits-1:0] i_bcd,
    output logic                            o_busy,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [CharBits-1:0]             o_character,
    output logic                            o_last_char
);

    localparam int LeftBits = $clog2(NUM_DIGITS + 1);
    localparam int BcdBits  = NUM_DIGITS * DigitBits;

    logic [BcdBits-1:0]   r_dig, n_dig;
    logic [LeftBits-1:0]  r_left, n_left;
    logic                 r_sign, n_sign;
    logic                 r_started, n_started;
    logic                 r_valid, n_valid;
    logic [CharBits-1:0]  r_char, n_char;
    logic                 r_last, n_last;
    logic                 can_adv;
    logic [DigitBits-1:0] top_dig;

    assign can_adv = !r_valid || !i_out_stall;
    assign top_dig = r_dig[BcdBits-1 -: DigitBits];

    always_comb begin
        n_dig     = r_dig;
        n_left    = r_left;
        n_sign    = r_sign;
        n_started = r_started;
        n_valid   = r_valid && i_out_stall;
        n_char    = r_char;
        n_last    = r_last;
        if (i_load) begin
            n_dig     = i_bcd;
            n_left    = LeftBits'(NUM_DIGITS);
            n_sign    = i_neg;
            n_started = 1'b0;
        end else if (can_adv && (r_sign || r_left != '0)) begin
            if (r_sign) begin
                n_sign  = 1'b0;
                n_valid = 1'b1;
                n_char  = CharMinus;
                n_last  = 1'b0;
            end else if (!r_started && top_dig == '0 && r_left > LeftBits'(1)) begin
                // Leading zero: drop it without producing a word.
                n_dig  = {r_dig[BcdBits-DigitBits-1:0], {DigitBits{1'b0}}};
                n_left = r_left - LeftBits'(1);
            end else begin
                n_dig     = {r_dig[BcdBits-DigitBits-1:0], {DigitBits{1'b0}}};
                n_left    = r_left - LeftBits'(1);
                n_started = 1'b1;
                n_valid   = 1'b1;
                n_char    = CharZero + CharBits'(top_dig);
                n_last    = (r_left == LeftBits'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_sign    <= 1'b0;
            r_started <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_left    <= n_left;
            r_sign    <= n_sign;
            r_started <= n_started;
            r_valid   <= n_valid;
        end
        r_dig  <= n_dig;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_busy      = r_sign || (r_left != '0);
    assign o_out_valid = r_valid;
    assign o_character = r_char;
    assign o_last_char = r_last;

endmodule

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
// Signed integer to decimal ASCII text converter, top level.
//
// Each accepted word is a signed two's complement integer of VALUE_BITS bits;
// the block returns its decimal text one character per output word, most
// significant first, with a leading '-' for negative values, a single '0'
// for zero, no leading zeros, and o_last_char set on the final character.
// The magnitude runs through a bit-serial shift-and-add-3 converter, one
// bit per cycle, and the BCD digits are then shifted out one per cycle
// while the output is not stalled, leading zeros included. A new number is
// taken once the previous one's digits have all moved to the output
// register, so the final character may still wait there.
module signed_int_to_decimal_ascii_unit
    import s2d_pkg::*;
#(
    parameter int VALUE_BITS = DefaultValueBits
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CharBits-1:0]   o_character,
    output logic                  o_last_char
);

    `include "signed_int_to_decimal_ascii_unit_assert.svh"

    // Decimal digits of the largest magnitude, 2^(VALUE_BITS-1).
    localparam int NumDigits = ((VALUE_BITS - 1) * 30103) / 100000 + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    logic                         r_neg, n_neg;
    logic                         in_acc;
    logic                         emit_load;
    logic                         emit_busy;
    logic [VALUE_BITS-1:0]        mag;
    logic [NumDigits*DigitBits-1:0] bcd;
    t_dab_status                  dab_status;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // The negation is taken as unsigned, so the most negative value works.
    assign mag = i_value[VALUE_BITS-1] ? (~i_value + VALUE_BITS'(1)) : i_value;

    assign emit_load = (r_state == ST_CONV) && dab_status.done;

    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_CONV;
                    n_neg   = i_value[VALUE_BITS-1];
                end
            end
            ST_CONV: begin
                if (dab_status.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!emit_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_neg <= n_neg;
    end

    s2d_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NumDigits)
    ) u_dabble (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_acc),
        .i_mag    (mag),
        .o_bcd    (bcd),
        .o_status (dab_status)
    );

    s2d_emit #(
        .NUM_DIGITS (NumDigits)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (emit_load),
        .i_neg       (r_neg),
        .i_bcd       (bcd),
        .o_busy      (emit_busy),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_character (o_character),
        .o_last_char (o_last_char)
    );

    `S2D_ASSERT_NEXT(a_accept_starts_conv, i_clk, i_rst_n, in_acc,
        r_state == ST_CONV && dab_status.busy,
        "accepted word did not start a conversion")
    `S2D_ASSERT_IMPLY(a_done_only_in_conv, i_clk, i_rst_n, dab_status.done,
        r_state == ST_CONV,
        "conversion finished outside the convert state")
    `S2D_ASSERT_IMPLY(a_minus_not_last, i_clk, i_rst_n,
        o_out_valid && o_character == CharMinus, !o_last_char,
        "minus sign marked as last character")
    `S2D_ASSERT_IMPLY(a_char_legal, i_clk, i_rst_n, o_out_valid,
        o_character == CharMinus ||
        (o_character >= CharZero && o_character <= CharZero + CharBits'(DigitNine)),
        "output character is neither a digit nor a minus sign")

endmodule
